[src/serial_command_frame_parser_top_macros.svh]
// Assertion macros of the serial command frame parser, used by the replay engine.
`ifndef SERIAL_COMMAND_FRAME_PARSER_TOP_MACROS_SVH
`define SERIAL_COMMAND_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCFP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCFP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/scfp_pkg.sv]
// Shared constants and types of the serial command frame parser.
package scfp_pkg;

  localparam int BODY_DEPTH = 64;
  localparam int ADDR_W     = $clog2(BODY_DEPTH);
  localparam int CNT_W      = $clog2(BODY_DEPTH + 1);
  localparam int CMP_W      = (CNT_W > 8) ? CNT_W : 8;
  localparam int IDX_W      = 6;
  localparam int PAYLOAD_W  = 18;
  localparam int TDATA_W    = 24;

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [7:0] HDR_SOF       = 8'hF5;
  localparam logic [7:0] HDR_SYNC      = 8'h8A;
  localparam logic [7:0] BYTE_TERM     = 8'h26;
  localparam logic [7:0] BYTE_EOF      = 8'hFA;
  localparam logic [7:0] CMD_LONG_LO   = 8'h0C;
  localparam logic [7:0] CMD_LONG_HI   = 8'h0F;
  localparam logic [7:0] CMD_LONG_ADDR = 8'h20;

  localparam logic [15:0] SUM_SEED =
    16'(HDR_SOF) + 16'(HDR_SYNC) + 16'(BYTE_EOF) + 16'(BYTE_TERM);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CKSUM    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_CHAN = 2'd1;
  localparam logic [1:0] LVL_ALL  = 2'd2;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
    logic [1:0]       level;
  } job_t;

endpackage

[src/serial_command_frame_parser_top.sv]
// Top level of the serial command frame parser: channel register, parser, queue, store, replay.
// Input: one byte per cycle; s_tready drops while the job queue is full, or while a body byte
// arrives before the previous frame's replay has finished reading the body store.
// The first result item follows the second checksum byte through the job queue and replay engine.
// Each replayed body byte takes a store read, an output load and a handshake.
// Reset (rst, synchronous, active high) clears the parser, queue, replay engine and channel
// register; the body store is not cleared and needs no clearing pass.
module serial_command_frame_parser_top import scfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,      // channel_index
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,        // [7:0] rx_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  // [1:0] status, [9:2] body_byte, [15:10] body_index, [17:16] reconfig_level, rest zero
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast         // last
);

  logic              [1:0] channel_index;
  logic                    q_push;
  logic                    q_full;
  logic                    q_empty;
  logic                    q_pop;
  job_t                    front_job;
  job_t                    head_job;
  store_wr_t               store_wr;
  logic [ADDR_W-1:0]       rd_addr;
  logic [7:0]              rd_data;
  logic                    replay_busy;
  logic [1:0]              out_status;
  logic [7:0]              out_byte;
  logic [IDX_W-1:0]        out_index;
  logic [1:0]              out_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index <= 2'd0;
    end else if (cfg_we) begin
      channel_index <= cfg_wdata;
    end
  end

  scfp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .channel_index (channel_index),
    .in_valid      (s_tvalid),
    .in_byte       (s_tdata),
    .in_ready      (s_tready),
    .back_busy     (replay_busy || !q_empty),
    .q_full        (q_full),
    .push          (q_push),
    .job           (front_job),
    .wr            (store_wr)
  );

  scfp_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  scfp_body_store u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  scfp_replay u_replay (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head_job   (head_job),
    .pop        (q_pop),
    .busy       (replay_busy),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_byte   (out_byte),
    .out_index  (out_index),
    .out_level  (out_level),
    .out_last   (m_tlast)
  );

  assign m_tdata = {{(TDATA_W - PAYLOAD_W){1'b0}}, out_level, out_index, out_byte, out_status};

endmodule

[src/scfp_front.sv]
// Frame parser: hunts headers, stores the body, checks the checksum, queues jobs.
module scfp_front import scfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] channel_index,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  input  logic       back_busy,
  input  logic       q_full,
  output logic       push,
  output job_t       job,
  output store_wr_t  wr
);

  typedef enum logic [2:0] {
    PH_HUNT_F5 = 3'd0,
    PH_HUNT_8A = 3'd1,
    PH_LEN     = 3'd2,
    PH_DATA    = 3'd3,
    PH_WAIT_FA = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  localparam logic [7:0] CMD_ALL_A  = 8'h00;
  localparam logic [7:0] CMD_ALL_B  = 8'h05;
  localparam logic [7:0] CMD_ALL_C  = 8'h06;
  localparam logic [7:0] GRP_A_LO   = 8'h01;
  localparam logic [7:0] GRP_A_HI   = 8'h04;
  localparam logic [7:0] GRP_B_LO   = 8'h08;
  localparam logic [7:0] GRP_B_HI   = 8'h1F;
  localparam logic [7:0] GRP_C_LO   = 8'h21;
  localparam logic [7:0] GRP_C_HI   = 8'h24;

  function automatic logic [1:0] level_of(input logic [7:0] cmd, input logic [1:0] chan);
    logic [7:0] diff;
    logic       grp;
    diff = 8'h00;
    grp  = 1'b0;
    if (cmd == CMD_ALL_A || cmd == CMD_ALL_B || cmd == CMD_ALL_C || cmd == CMD_LONG_ADDR) begin
      return LVL_ALL;
    end
    if (cmd >= GRP_A_LO && cmd <= GRP_A_HI) begin
      grp  = 1'b1;
      diff = cmd - GRP_A_LO;
    end else if (cmd >= GRP_B_LO && cmd <= GRP_B_HI) begin
      grp  = 1'b1;
      diff = {6'b0, cmd[1:0]};
    end else if (cmd >= GRP_C_LO && cmd <= GRP_C_HI) begin
      grp  = 1'b1;
      diff = cmd - GRP_C_LO;
    end
    return (grp && diff == {6'b0, chan}) ? LVL_CHAN : LVL_NONE;
  endfunction

  phase_t           phase;
  logic [CNT_W-1:0] body_count;
  logic [7:0]       declared_length;
  logic [7:0]       checksum_high;
  logic             checksum_bytes_seen;
  logic [15:0]      sum;
  logic [7:0]       cmd;

  logic accept;
  logic is_term;
  logic store_full;
  logic sum_match;

  // The store is still being replayed while a job is queued or in progress.
  assign in_ready   = !q_full && !(phase == PH_DATA && back_busy);
  assign accept     = in_valid && in_ready;
  assign store_full = (body_count == CNT_W'(BODY_DEPTH));
  assign is_term    = (in_byte == BYTE_TERM) && (body_count != '0) &&
                      (CMP_W'(body_count) > CMP_W'(declared_length));
  assign sum_match  = (sum == {checksum_high, in_byte});

  always_comb begin
    wr.en   = accept && (phase == PH_DATA) && !is_term && !store_full;
    wr.addr = body_count[ADDR_W-1:0];
    wr.data = in_byte;
    push    = accept && (((phase == PH_DATA) && !is_term && store_full) ||
                         ((phase == PH_CHECK) && checksum_bytes_seen));
    job.count = body_count;
    if (phase == PH_DATA) begin
      job.status = ST_OVERFLOW;
      job.level  = LVL_NONE;
    end else if (sum_match) begin
      job.status = ST_OK;
      job.level  = level_of(cmd, channel_index);
    end else begin
      job.status = ST_CKSUM;
      job.level  = LVL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_HUNT_F5;
      body_count          <= '0;
      declared_length     <= '0;
      checksum_high       <= '0;
      checksum_bytes_seen <= 1'b0;
    end else if (accept) begin
      unique case (phase)
        PH_HUNT_8A: begin
          if (in_byte == HDR_SYNC) begin
            body_count      <= '0;
            declared_length <= '0;
            sum             <= SUM_SEED;
            phase           <= PH_DATA;
          end
        end
        PH_LEN: begin
          declared_length <= in_byte;
          sum             <= sum + {8'h00, in_byte};
          phase           <= PH_DATA;
        end
        PH_DATA: begin
          if (is_term) begin
            phase <= PH_WAIT_FA;
          end else if (store_full) begin
            phase               <= PH_HUNT_F5;
            checksum_bytes_seen <= 1'b0;
          end else begin
            sum        <= sum + {8'h00, in_byte};
            body_count <= body_count + CNT_W'(1);
            if (body_count == '0) begin
              cmd <= in_byte;
              if ((in_byte >= CMD_LONG_LO && in_byte <= CMD_LONG_HI) ||
                  in_byte == CMD_LONG_ADDR) begin
                phase <= PH_LEN;
              end
            end
          end
        end
        PH_WAIT_FA: begin
          if (in_byte == BYTE_EOF) begin
            checksum_bytes_seen <= 1'b0;
            phase               <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (!checksum_bytes_seen) begin
            checksum_high       <= in_byte;
            checksum_bytes_seen <= 1'b1;
          end else begin
            checksum_bytes_seen <= 1'b0;
            phase               <= PH_HUNT_F5;
          end
        end
        default: begin
          phase <= (in_byte == HDR_SOF) ? PH_HUNT_8A : PH_HUNT_F5;
        end
      endcase
    end
  end

endmodule

[src/scfp_job_queue.sv]
// Short queue of replay and failure jobs between the parser and the replay engine.
module scfp_job_queue import scfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head_job
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[src/scfp_body_store.sv]
// Frame body memory: one write port, one registered read port.
module scfp_body_store import scfp_pkg::*; (
  input  logic              clk,
  input  store_wr_t         wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [BODY_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/scfp_replay.sv]
// Replay engine: turns queued jobs into result items, reading the body store.
`include "serial_command_frame_parser_top_macros.svh"

module scfp_replay import scfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  job_t              head_job,
  output logic              pop,
  output logic              busy,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [7:0]        out_byte,
  output logic [IDX_W-1:0]  out_index,
  output logic [1:0]        out_level,
  output logic              out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_SHOW
  } state_t;

  state_t            state;
  job_t              cur;
  logic [ADDR_W-1:0] idx;

  assign pop     = (state == ST_IDLE) && !q_empty;
  assign busy    = (state != ST_IDLE);
  assign rd_addr = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cur <= head_job;
            idx <= '0;
            if (head_job.status == ST_OK) begin
              state <= ST_FETCH;
            end else begin
              out_valid  <= 1'b1;
              out_status <= head_job.status;
              out_byte   <= 8'h00;
              out_index  <= '0;
              out_level  <= LVL_NONE;
              out_last   <= 1'b1;
              state      <= ST_SHOW;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          out_valid  <= 1'b1;
          out_status <= ST_OK;
          out_byte   <= rd_data;
          out_index  <= IDX_W'(idx);
          out_level  <= cur.level;
          out_last   <= (CNT_W'(idx) + CNT_W'(1) == cur.count);
          state      <= ST_SHOW;
        end
        ST_SHOW: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + ADDR_W'(1);
              state <= ST_FETCH;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SCFP_ASSERT_IMP(a_fetch_in_body, clk, rst, state == ST_FETCH, CNT_W'(idx) < cur.count, "replay read past the stored body")
  `SCFP_ASSERT_IMP(a_fail_is_last, clk, rst, out_valid && out_status != ST_OK, out_last, "failure item without last")
  `SCFP_ASSERT_NXT(a_next_fetch, clk, rst, state == ST_SHOW && out_ready && !out_last, state == ST_FETCH, "replay did not move to the next byte")

endmodule
